FILE: rtl/xs256_pkg.sv
// Shared types, constants and helpers for the xoshiro256** generator.
package xs256_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = DATA_W / 2;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS);

  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_RAW = 2'd1;
  localparam logic [1:0] OP_BOUNDED = 2'd2;
  localparam logic [1:0] OP_FRACTION = 2'd3;

  localparam logic [DATA_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [DATA_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [DATA_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;
  localparam int unsigned XO_SHIFT = 17;
  localparam int unsigned XO_ROT = 45;
  localparam int unsigned OUT_ROT = 7;
  localparam int unsigned FRAC_SHIFT = 11;

  typedef struct packed {
    logic [1:0] opcode;
    logic [DATA_W-1:0] bound;
  } xs256_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] random_value;
    logic bad_bound;
  } xs256_rsp_t;

  typedef enum logic [2:0] {
    CmdReseed,
    CmdRaw,
    CmdBounded,
    CmdFrac,
    CmdBadBound
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic [DATA_W-1:0] bound;
  } xs256_cmd_t;

  function automatic logic [DATA_W-1:0] rotl64(input logic [DATA_W-1:0] x,
                                               input int unsigned k);
    return (x << k) | (x >> (DATA_W - k));
  endfunction

endpackage

FILE: rtl/xs256_fifo.sv
// Small first-in first-out queue of packed beats.
module xs256_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic push_ok, pop_ok;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok = pop_i && !empty_o;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/xs256_front.sv
// Front end: accepts requests, classifies them and queues the commands.
module xs256_front
  import xs256_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  xs256_req_t req_i,
  output logic       full_o,
  input  logic       cmd_pop_i,
  output xs256_cmd_t cmd_o,
  output logic       cmd_empty_o
);

  xs256_cmd_t cmd_in;
  logic [$bits(xs256_cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.bound = req_i.bound;
    case (req_i.opcode)
      OP_RESEED: cmd_in.kind = CmdReseed;
      OP_RAW: cmd_in.kind = CmdRaw;
      OP_BOUNDED: cmd_in.kind = (req_i.bound == '0) ? CmdBadBound : CmdBounded;
      OP_FRACTION: cmd_in.kind = CmdFrac;
      default: cmd_in.kind = CmdRaw;
    endcase
  end

  xs256_fifo #(
    .Width($bits(xs256_cmd_t)),
    .Depth(Depth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_bits),
    .empty_o(cmd_empty_o)
  );

  assign cmd_o = xs256_cmd_t'(cmd_bits);

endmodule

FILE: rtl/xs256_mul.sv
// Low half of a 64 by 64 bit product, built from one shared 32 by 32 multiplier.
module xs256_mul
  import xs256_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] prod_o
);

  logic [DATA_W-1:0] a_q, b_q, prod_q, acc_q;
  logic [1:0] step_q;
  logic busy_q, done_q;
  logic [HALF_W-1:0] op_a, op_b;

  always_comb begin
    case (step_q)
      2'd0: begin
        op_a = a_q[HALF_W-1:0];
        op_b = b_q[HALF_W-1:0];
      end
      2'd1: begin
        op_a = a_q[HALF_W-1:0];
        op_b = b_q[DATA_W-1:HALF_W];
      end
      default: begin
        op_a = a_q[DATA_W-1:HALF_W];
        op_b = b_q[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      prod_q <= '0;
      acc_q <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q <= a_i;
        b_q <= b_i;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        prod_q <= op_a * op_b;
        step_q <= step_q + 1'b1;
        case (step_q)
          2'd1: acc_q <= prod_q;
          2'd2: acc_q[DATA_W-1:HALF_W] <= acc_q[DATA_W-1:HALF_W] + prod_q[HALF_W-1:0];
          2'd3: begin
            acc_q[DATA_W-1:HALF_W] <= acc_q[DATA_W-1:HALF_W] + prod_q[HALF_W-1:0];
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
          default: acc_q <= acc_q;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/xs256_div.sv
// Restoring divider that yields the 64-bit remainder, one bit per cycle.
module xs256_div
  import xs256_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] num_i,
  input  logic [DATA_W-1:0] den_i,
  output logic              done_o,
  output logic [DATA_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DATA_W);

  logic [DATA_W-1:0] num_q, den_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [DATA_W:0] trial, diff;
  logic fits;

  assign trial = {rem_q, num_q[DATA_W-1]};
  assign diff = trial - {1'b0, den_q};
  assign fits = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      den_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q <= num_i;
        den_q <= den_i;
        rem_q <= '0;
        cnt_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o = rem_q;

endmodule

FILE: rtl/xs256_back.sv
// Back end: holds the generator state and carries out queued commands.
module xs256_back
  import xs256_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_write_i,
  input  logic [DATA_W-1:0] cfg_seed_i,
  input  xs256_cmd_t        cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output xs256_rsp_t        rsp_o,
  output logic              rsp_push_o,
  input  logic              rsp_full_i
);

  typedef enum logic [3:0] {
    StIdle,
    StMixAdd,
    StMulA,
    StMulB,
    StRawA,
    StRawB,
    StFloor,
    StMod,
    StPush
  } state_e;

  state_e state_q;
  logic [DATA_W-1:0] gen_q [NUM_WORDS];
  logic [DATA_W-1:0] seed_q, ctr_q, z_q, p5_q, floor_q, bound_q;
  logic [DATA_W-1:0] mul_b_q, div_num_q, div_den_q;
  logic [WORD_IDX_W-1:0] idx_q;
  logic init_q, mul_start_q, div_start_q;
  cmd_kind_e kind_q;
  xs256_rsp_t res_q;

  logic mul_done, div_done;
  logic [DATA_W-1:0] mul_prod, div_rem;
  logic [DATA_W-1:0] ctr_next, rot_w, raw_w, t_w;

  assign ctr_next = ctr_q + GOLDEN_STEP;
  assign rot_w = rotl64(p5_q, OUT_ROT);
  assign raw_w = rot_w + (rot_w << 3);
  assign t_w = gen_q[1] << XO_SHIFT;

  assign cmd_pop_o = (state_q == StIdle) && !cmd_empty_i;
  assign rsp_push_o = (state_q == StPush) && !rsp_full_i;
  assign rsp_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StMixAdd;
      seed_q <= '0;
      ctr_q <= '0;
      z_q <= '0;
      p5_q <= '0;
      floor_q <= '0;
      bound_q <= '0;
      mul_b_q <= '0;
      div_num_q <= '0;
      div_den_q <= '0;
      idx_q <= '0;
      init_q <= 1'b1;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      kind_q <= CmdReseed;
      res_q <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        gen_q[i] <= '0;
      end
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (cfg_write_i) begin
        seed_q <= cfg_seed_i;
      end
      case (state_q)
        StIdle: begin
          if (!cmd_empty_i) begin
            kind_q <= cmd_i.kind;
            bound_q <= cmd_i.bound;
            case (cmd_i.kind)
              CmdReseed: begin
                ctr_q <= seed_q;
                idx_q <= '0;
                state_q <= StMixAdd;
              end
              CmdRaw, CmdFrac: state_q <= StRawA;
              CmdBounded: begin
                div_num_q <= '0 - cmd_i.bound;
                div_den_q <= cmd_i.bound;
                div_start_q <= 1'b1;
                state_q <= StFloor;
              end
              CmdBadBound: begin
                res_q.random_value <= '0;
                res_q.bad_bound <= 1'b1;
                state_q <= StPush;
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StMixAdd: begin
          ctr_q <= ctr_next;
          z_q <= ctr_next ^ (ctr_next >> MIX_SHIFT_A);
          mul_b_q <= MIX_MUL_A;
          mul_start_q <= 1'b1;
          state_q <= StMulA;
        end
        StMulA: begin
          if (mul_done) begin
            z_q <= mul_prod ^ (mul_prod >> MIX_SHIFT_B);
            mul_b_q <= MIX_MUL_B;
            mul_start_q <= 1'b1;
            state_q <= StMulB;
          end
        end
        StMulB: begin
          if (mul_done) begin
            gen_q[idx_q] <= mul_prod ^ (mul_prod >> MIX_SHIFT_C);
            if (idx_q == WORD_IDX_W'(NUM_WORDS - 1)) begin
              res_q <= '0;
              init_q <= 1'b0;
              state_q <= init_q ? StIdle : StPush;
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= StMixAdd;
            end
          end
        end
        StRawA: begin
          p5_q <= gen_q[1] + (gen_q[1] << 2);
          gen_q[0] <= gen_q[0] ^ gen_q[3] ^ gen_q[1];
          gen_q[1] <= gen_q[1] ^ gen_q[2] ^ gen_q[0];
          gen_q[2] <= gen_q[2] ^ gen_q[0] ^ t_w;
          gen_q[3] <= rotl64(gen_q[3] ^ gen_q[1], XO_ROT);
          state_q <= StRawB;
        end
        StRawB: begin
          res_q.bad_bound <= 1'b0;
          case (kind_q)
            CmdRaw: begin
              res_q.random_value <= raw_w;
              state_q <= StPush;
            end
            CmdFrac: begin
              res_q.random_value <= raw_w >> FRAC_SHIFT;
              state_q <= StPush;
            end
            CmdBounded: begin
              if (raw_w < floor_q) begin
                state_q <= StRawA;
              end else begin
                div_num_q <= raw_w;
                div_den_q <= bound_q;
                div_start_q <= 1'b1;
                state_q <= StMod;
              end
            end
            default: state_q <= StIdle;
          endcase
        end
        StFloor: begin
          if (div_done) begin
            floor_q <= div_rem;
            state_q <= StRawA;
          end
        end
        StMod: begin
          if (div_done) begin
            res_q.random_value <= div_rem;
            res_q.bad_bound <= 1'b0;
            state_q <= StPush;
          end
        end
        StPush: begin
          if (!rsp_full_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  xs256_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .a_i    (z_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  xs256_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o |=> !rsp_push_o)
    else $error("Two result beats pushed for one command.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_push_o && res_q.bad_bound) |-> (res_q.random_value == '0))
    else $error("Bad bound result carries a non-zero value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_push_o && kind_q == CmdFrac) |-> (res_q.random_value[DATA_W-1:DATA_W-FRAC_SHIFT] == '0))
    else $error("Fraction result wider than 53 bits.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_push_o && kind_q == CmdBounded) |-> (res_q.random_value < bound_q))
    else $error("Bounded result not below its bound.");
`endif

endmodule

FILE: rtl/xoshiro256ss_generator_top.sv
// Top level of the xoshiro256** generator with queue-style request and result ports.
//
//   Channel   Handshake                  Payload
//   request   push / full                req_i (opcode, bound)
//   result    empty / pop                rsp_o (random_value, bad_bound)
//   seed      cfg_valid_i / cfg_ready_o  cfg_seed_value_i
//
// A raw word or a fraction takes one state update; a reseed takes
// eight multiplications on the shared 32 by 32 multiplier; a bounded value takes
// two passes of the one-bit-per-cycle divider, plus one more state update per rejected word.
// After reset the state is expanded from seed 0; requests queue meanwhile.
// A full result queue stalls the back end; the request queue keeps taking beats until it
// is full too.
module xoshiro256ss_generator_top
  import xs256_pkg::*;
#(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned RspDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  xs256_req_t        req_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output xs256_rsp_t        rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DATA_W-1:0] cfg_seed_value_i
);

  xs256_cmd_t cmd;
  logic cmd_empty, cmd_pop;
  xs256_rsp_t rsp_back;
  logic rsp_push, rsp_full;
  logic [$bits(xs256_rsp_t)-1:0] rsp_bits;

  assign cfg_ready_o = 1'b1;

  xs256_front #(
    .Depth(CmdDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_empty_o(cmd_empty)
  );

  xs256_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_write_i(cfg_valid_i && cfg_ready_o),
    .cfg_seed_i (cfg_seed_value_i),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .rsp_o      (rsp_back),
    .rsp_push_o (rsp_push),
    .rsp_full_i (rsp_full)
  );

  xs256_fifo #(
    .Width($bits(xs256_rsp_t)),
    .Depth(RspDepth)
  ) u_rsp_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_push),
    .data_i (rsp_back),
    .full_o (rsp_full),
    .pop_i  (pop),
    .data_o (rsp_bits),
    .empty_o(empty)
  );

  assign rsp_o = xs256_rsp_t'(rsp_bits);

endmodule
